### src/ucsc_pkg.sv
package ucsc_pkg;

   // charge state codes
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CHARGING = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_RECHARGE = 3'd3;
   localparam logic [2:0] ST_OVP      = 3'd4;

   // response kinds
   localparam logic [2:0] K_STATUS  = 3'd0;
   localparam logic [2:0] K_EVENT   = 3'd1;
   localparam logic [2:0] K_ENABLE  = 3'd2;
   localparam logic [2:0] K_CURRENT = 3'd3;
   localparam logic [2:0] K_UNLOCK  = 3'd4;

   // event codes
   localparam logic [3:0] EV_LOCK     = 4'd0;
   localparam logic [3:0] EV_OVP      = 4'd1;
   localparam logic [3:0] EV_INPUT    = 4'd2;
   localparam logic [3:0] EV_FULL     = 4'd3;
   localparam logic [3:0] EV_CHARGING = 4'd4;
   localparam logic [3:0] EV_REMOVE   = 4'd5;

   // register indexes
   localparam logic [2:0] REG_FULL_V      = 3'd0;
   localparam logic [2:0] REG_RECHARGE_V  = 3'd1;
   localparam logic [2:0] REG_REDUCE_V    = 3'd2;
   localparam logic [2:0] REG_NORMAL_CUR  = 3'd3;
   localparam logic [2:0] REG_REDUCED_CUR = 3'd4;
   localparam logic [2:0] REG_FULL_TICKS  = 3'd5;
   localparam logic [2:0] REG_RED_TICKS   = 3'd6;
   localparam logic [2:0] REG_FEATURES    = 3'd7;

   // fixed behavior constants
   localparam logic [7:0] INSERT_DEBOUNCE    = 8'd10;
   localparam logic [7:0] OVP_DEBOUNCE       = 8'd10;
   localparam logic [3:0] CURRENT_500MA_CODE = 4'd7;
   localparam int         RAMP_STEPS         = 5;

   // ramp period = full_ticks / RAMP_STEPS by reciprocal multiply
   localparam int          RAMP_SHIFT = 20;
   localparam int          RAMP_RECIP_INT = (2**RAMP_SHIFT + RAMP_STEPS - 1) / RAMP_STEPS;
   localparam logic [20:0] RAMP_RECIP = RAMP_RECIP_INT[20:0];

   // action slots per tick, status item excluded
   localparam int ACT_SLOTS = 7;

   typedef struct packed {
      logic [12:0] full_voltage_mv;
      logic [12:0] recharge_voltage_mv;
      logic [12:0] reduce_voltage_mv;
      logic [3:0]  normal_current_code;
      logic [3:0]  reduced_current_code;
      logic [15:0] full_ticks;
      logic [15:0] reduce_ticks;
      logic [2:0]  feature_enables;
   } cfg_type;

   typedef struct packed {
      logic        usb_present;
      logic        overvoltage;
      logic        hardware_full;
      logic        charger_on;
      logic [12:0] battery_mv;
      logic        system_busy;
   } req_item_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic div_start;
      logic ramp_apply;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic ramp_need;
      logic div_done;
      logic out_free;
      logic at_status;
   } status_type;

endpackage

### src/ucsc_if.sv
interface ucsc_req_if;
   logic        valid;
   logic        ready;
   logic        usb_present;
   logic        overvoltage;
   logic        hardware_full;
   logic        charger_on;
   logic [12:0] battery_mv;
   logic        system_busy;

   modport source (output valid, usb_present, overvoltage, hardware_full, charger_on,
                   battery_mv, system_busy, input ready);
   modport sink (input valid, usb_present, overvoltage, hardware_full, charger_on,
                 battery_mv, system_busy, output ready);
endinterface

interface ucsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [3:0] value;
   logic [2:0] charge_state;
   logic       last;

   modport source (output valid, kind, value, charge_state, last, input ready);
   modport sink (input valid, kind, value, charge_state, last, output ready);
endinterface

### src/ucsc_csr.sv
module ucsc_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output ucsc_pkg::cfg_type cfg
);

   ucsc_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [2:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_voltage_mv      <= 13'd4200;
         cfg_ff.recharge_voltage_mv  <= 13'd4050;
         cfg_ff.reduce_voltage_mv    <= 13'd4100;
         cfg_ff.normal_current_code  <= 4'd7;
         cfg_ff.reduced_current_code <= 4'd3;
         cfg_ff.full_ticks           <= 16'd600;
         cfg_ff.reduce_ticks         <= 16'd300;
         cfg_ff.feature_enables      <= 3'd7;
      end else if (wr_en) begin
         case (reg_idx)
            ucsc_pkg::REG_FULL_V:      cfg_ff.full_voltage_mv      <= pwdata[12:0];
            ucsc_pkg::REG_RECHARGE_V:  cfg_ff.recharge_voltage_mv  <= pwdata[12:0];
            ucsc_pkg::REG_REDUCE_V:    cfg_ff.reduce_voltage_mv    <= pwdata[12:0];
            ucsc_pkg::REG_NORMAL_CUR:  cfg_ff.normal_current_code  <= pwdata[3:0];
            ucsc_pkg::REG_REDUCED_CUR: cfg_ff.reduced_current_code <= pwdata[3:0];
            ucsc_pkg::REG_FULL_TICKS:  cfg_ff.full_ticks           <= pwdata[15:0];
            ucsc_pkg::REG_RED_TICKS:   cfg_ff.reduce_ticks         <= pwdata[15:0];
            default:                   cfg_ff.feature_enables      <= pwdata[2:0];
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         ucsc_pkg::REG_FULL_V:      prdata = {19'd0, cfg_ff.full_voltage_mv};
         ucsc_pkg::REG_RECHARGE_V:  prdata = {19'd0, cfg_ff.recharge_voltage_mv};
         ucsc_pkg::REG_REDUCE_V:    prdata = {19'd0, cfg_ff.reduce_voltage_mv};
         ucsc_pkg::REG_NORMAL_CUR:  prdata = {28'd0, cfg_ff.normal_current_code};
         ucsc_pkg::REG_REDUCED_CUR: prdata = {28'd0, cfg_ff.reduced_current_code};
         ucsc_pkg::REG_FULL_TICKS:  prdata = {16'd0, cfg_ff.full_ticks};
         ucsc_pkg::REG_RED_TICKS:   prdata = {16'd0, cfg_ff.reduce_ticks};
         default:                   prdata = {29'd0, cfg_ff.feature_enables};
      endcase
   end

endmodule

### src/ucsc_div.sv
module ucsc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] quotient,
   output logic [15:0] remainder
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [16:0] trial;
   logic        fits;

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   // one restoring step per cycle, msb first
   assign trial = {rem_ff, quo_ff[15]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         quo_in  = dividend;
         rem_in  = 16'd0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? 16'(trial - {1'b0, dvs_ff}) : trial[15:0];
         quo_in = {quo_ff[14:0], fits};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

### src/ucsc_ctrl.sv
module ucsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ucsc_pkg::status_type stat,
   output ucsc_pkg::cmd_type    cmd
);

   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_EVAL = 2'd1;
   localparam logic [1:0] C_DIV  = 2'd2;
   localparam logic [1:0] C_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_ready = state_ff == C_IDLE;

   // sequencing of one request
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      case (state_ff)
         C_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = C_EVAL;
            end
         end
         C_EVAL: begin
            cmd.eval = 1'b1;
            if (stat.ramp_need) begin
               cmd.div_start = 1'b1;
               state_in      = C_DIV;
            end else begin
               state_in = C_EMIT;
            end
         end
         C_DIV: begin
            if (stat.div_done) begin
               cmd.ramp_apply = 1'b1;
               state_in       = C_EMIT;
            end
         end
         C_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.at_status) begin
                  state_in = C_IDLE;
               end
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/ucsc_dp.sv
module ucsc_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  ucsc_pkg::cfg_type      cfg,
   input  ucsc_pkg::req_item_type req_item,
   input  ucsc_pkg::cmd_type      cmd,
   output ucsc_pkg::status_type   stat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_kind,
   output logic [3:0]             rsp_value,
   output logic [2:0]             rsp_charge_state,
   output logic                   rsp_last
);

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] value;
   } act_type;

   typedef struct packed {
      act_type [ucsc_pkg::ACT_SLOTS-1:0] acts;
      logic [2:0]                        n;
   } act_buf_type;

   // append one action unless the list is full
   function automatic act_buf_type push(act_buf_type b, logic [2:0] kind, logic [3:0] value);
      act_buf_type r;
      r = b;
      if (b.n < 3'(ucsc_pkg::ACT_SLOTS)) begin
         r.acts[b.n] = '{kind: kind, value: value};
         r.n         = b.n + 3'd1;
      end
      return r;
   endfunction

   ucsc_pkg::req_item_type in_ff;
   logic [2:0]  state_ff, state_in;
   logic        ovp_lat_ff, ovp_lat_in;
   logic        full_lat_ff, full_lat_in;
   logic [7:0]  ins_cnt_ff, ins_cnt_in;
   logic [7:0]  ovp_clr_ff, ovp_clr_in;
   logic [15:0] full_cnt_ff, full_cnt_in;
   logic [15:0] red_cnt_ff, red_cnt_in;
   act_buf_type buf_ff, buf_in;
   logic        ramp_need;
   logic [2:0]  emit_idx_ff;
   logic        at_status;
   logic        soft_full_en;

   logic [36:0] per_prod;
   logic [15:0] per_ff;
   logic        div_done;
   logic [15:0] div_quo;
   logic [15:0] div_rem;
   logic [3:0]  ramp_top;
   logic [3:0]  ramp_code;
   act_type     cur_act;

   logic       rsp_valid_ff;
   logic [2:0] rsp_kind_ff;
   logic [3:0] rsp_value_ff;
   logic [2:0] rsp_state_ff;
   logic       rsp_last_ff;

   assign soft_full_en = cfg.feature_enables[1];

   // ramp period, at least one tick
   assign per_prod = {21'd0, cfg.full_ticks} * {16'd0, ucsc_pkg::RAMP_RECIP};
   always_ff @(posedge clock) begin
      per_ff <= (per_prod[ucsc_pkg::RAMP_SHIFT +: 16] == 16'd0)
                ? 16'd1 : per_prod[ucsc_pkg::RAMP_SHIFT +: 16];
   end

   ucsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (full_cnt_in),
      .divisor   (per_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // ramped code saturates at zero
   assign ramp_top  = (cfg.normal_current_code > ucsc_pkg::CURRENT_500MA_CODE)
                      ? ucsc_pkg::CURRENT_500MA_CODE : cfg.normal_current_code;
   assign ramp_code = (div_quo >= {12'd0, ramp_top}) ? 4'd0 : 4'(ramp_top - div_quo[3:0]);

   // one tick of the charge state machine
   always_comb begin
      state_in    = state_ff;
      ovp_lat_in  = ovp_lat_ff;
      full_lat_in = full_lat_ff;
      ins_cnt_in  = ins_cnt_ff;
      ovp_clr_in  = ovp_clr_ff;
      full_cnt_in = full_cnt_ff;
      red_cnt_in  = red_cnt_ff;
      buf_in      = '0;
      ramp_need   = 1'b0;

      if (in_ff.usb_present && in_ff.charger_on) full_lat_in = in_ff.hardware_full;
      if (in_ff.usb_present) ovp_lat_in = in_ff.overvoltage;

      case (state_ff)
         ucsc_pkg::ST_IDLE: begin
            if (in_ff.usb_present) begin
               full_lat_in = 1'b0;
               buf_in = push(buf_in, ucsc_pkg::K_ENABLE, 4'd0);
               if (!in_ff.system_busy) begin
                  if (cfg.feature_enables[2]) begin
                     buf_in = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_LOCK);
                  end
                  buf_in = push(buf_in, ucsc_pkg::K_UNLOCK, 4'd0);
                  if (ovp_lat_in) begin
                     buf_in   = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_OVP);
                     state_in = ucsc_pkg::ST_OVP;
                  end
                  ins_cnt_in = ins_cnt_ff + 8'd1;
                  if (ins_cnt_in >= ucsc_pkg::INSERT_DEBOUNCE) begin
                     ins_cnt_in = 8'd0;
                     if (cfg.feature_enables[0]) begin
                        buf_in = push(buf_in, ucsc_pkg::K_CURRENT, cfg.normal_current_code);
                     end
                     buf_in   = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_INPUT);
                     state_in = ucsc_pkg::ST_CHARGING;
                     buf_in   = push(buf_in, ucsc_pkg::K_ENABLE, 4'd1);
                  end
               end
            end
         end
         ucsc_pkg::ST_CHARGING: begin
            if (!in_ff.usb_present) begin
               state_in = ucsc_pkg::ST_IDLE;
               buf_in   = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_REMOVE);
            end else begin
               if (ovp_lat_in) begin
                  buf_in   = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_OVP);
                  state_in = ucsc_pkg::ST_OVP;
               end
               if (full_lat_in) begin
                  full_cnt_in = 16'd0;
                  buf_in      = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_FULL);
                  state_in    = ucsc_pkg::ST_FULL;
               end
               if (cfg.feature_enables[0] && in_ff.battery_mv >= cfg.reduce_voltage_mv) begin
                  red_cnt_in = red_cnt_ff + 16'd1;
                  if (red_cnt_in >= cfg.reduce_ticks) begin
                     red_cnt_in = 16'd0;
                     buf_in = push(buf_in, ucsc_pkg::K_CURRENT, cfg.reduced_current_code);
                  end
               end
               if (soft_full_en && in_ff.battery_mv >= cfg.full_voltage_mv) begin
                  full_cnt_in = full_cnt_in + 16'd1;
                  if (full_cnt_in >= cfg.full_ticks) begin
                     full_cnt_in = 16'd0;
                     buf_in      = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_FULL);
                     state_in    = ucsc_pkg::ST_FULL;
                     buf_in      = push(buf_in, ucsc_pkg::K_ENABLE, 4'd0);
                  end
                  ramp_need = 1'b1;
               end
            end
         end
         ucsc_pkg::ST_FULL: begin
            if (!in_ff.usb_present) begin
               state_in = ucsc_pkg::ST_IDLE;
               buf_in   = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_REMOVE);
            end else if (soft_full_en) begin
               if (in_ff.battery_mv < cfg.recharge_voltage_mv) begin
                  buf_in   = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_CHARGING);
                  state_in = ucsc_pkg::ST_RECHARGE;
                  buf_in   = push(buf_in, ucsc_pkg::K_CURRENT, ucsc_pkg::CURRENT_500MA_CODE);
                  buf_in   = push(buf_in, ucsc_pkg::K_ENABLE, 4'd1);
               end else begin
                  buf_in = push(buf_in, ucsc_pkg::K_ENABLE, 4'd0);
               end
            end
         end
         ucsc_pkg::ST_RECHARGE: begin
            if (!in_ff.usb_present) begin
               state_in = ucsc_pkg::ST_IDLE;
               buf_in   = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_REMOVE);
            end else begin
               if (soft_full_en && in_ff.battery_mv >= cfg.full_voltage_mv) begin
                  full_cnt_in = full_cnt_ff + 16'd1;
                  if (full_cnt_in >= cfg.full_ticks) begin
                     full_cnt_in = 16'd0;
                     buf_in      = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_FULL);
                     state_in    = ucsc_pkg::ST_FULL;
                     buf_in      = push(buf_in, ucsc_pkg::K_ENABLE, 4'd0);
                  end
               end
               if (full_lat_in) begin
                  full_cnt_in = 16'd0;
                  buf_in      = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_FULL);
                  state_in    = ucsc_pkg::ST_FULL;
               end
            end
         end
         ucsc_pkg::ST_OVP: begin
            if (!in_ff.usb_present) begin
               ovp_lat_in = 1'b0;
               ovp_clr_in = 8'd0;
               state_in   = ucsc_pkg::ST_IDLE;
               buf_in     = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_REMOVE);
            end else if (!ovp_lat_in) begin
               if (in_ff.battery_mv >= cfg.full_voltage_mv) begin
                  buf_in   = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_FULL);
                  state_in = ucsc_pkg::ST_FULL;
                  buf_in   = push(buf_in, ucsc_pkg::K_ENABLE, 4'd0);
               end else begin
                  ovp_clr_in = ovp_clr_ff + 8'd1;
                  if (ovp_clr_in >= ucsc_pkg::OVP_DEBOUNCE) begin
                     ovp_clr_in = 8'd0;
                     buf_in     = push(buf_in, ucsc_pkg::K_EVENT, ucsc_pkg::EV_CHARGING);
                     state_in   = ucsc_pkg::ST_CHARGING;
                     buf_in     = push(buf_in, ucsc_pkg::K_CURRENT,
                                       ucsc_pkg::CURRENT_500MA_CODE);
                     buf_in     = push(buf_in, ucsc_pkg::K_ENABLE, 4'd1);
                  end
               end
            end
         end
         // unused codes fall back to idle
         default: state_in = ucsc_pkg::ST_IDLE;
      endcase
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_item;
      end
   end

   // controller state and action list
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ucsc_pkg::ST_IDLE;
         ovp_lat_ff  <= 1'b0;
         full_lat_ff <= 1'b0;
         ins_cnt_ff  <= 8'd0;
         ovp_clr_ff  <= 8'd0;
         full_cnt_ff <= 16'd0;
         red_cnt_ff  <= 16'd0;
         buf_ff      <= '0;
         emit_idx_ff <= 3'd0;
      end else begin
         if (cmd.eval) begin
            state_ff    <= state_in;
            ovp_lat_ff  <= ovp_lat_in;
            full_lat_ff <= full_lat_in;
            ins_cnt_ff  <= ins_cnt_in;
            ovp_clr_ff  <= ovp_clr_in;
            full_cnt_ff <= full_cnt_in;
            red_cnt_ff  <= red_cnt_in;
            buf_ff      <= buf_in;
            emit_idx_ff <= 3'd0;
         end else begin
            if (cmd.ramp_apply && div_rem == 16'd0) begin
               buf_ff <= push(buf_ff, ucsc_pkg::K_CURRENT, ramp_code);
            end
            if (cmd.emit) begin
               emit_idx_ff <= emit_idx_ff + 3'd1;
            end
         end
      end
   end

   // output register
   assign at_status = emit_idx_ff == buf_ff.n;
   assign cur_act   = buf_ff.acts[emit_idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff  <= at_status ? ucsc_pkg::K_STATUS : cur_act.kind;
         rsp_value_ff <= at_status ? 4'd0 : cur_act.value;
         rsp_state_ff <= state_ff;
         rsp_last_ff  <= at_status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_charge_state = rsp_state_ff;
   assign rsp_last         = rsp_last_ff;

   assign stat.ramp_need = ramp_need;
   assign stat.div_done  = div_done;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign stat.at_status = at_status;

endmodule

### src/usb_charge_state_controller.sv
// USB charge state controller. Each request is one charger tick (USB presence, over-voltage,
// charge-complete, charger enable, battery voltage, system busy); the block steps its
// idle/charging/full/recharge/over-voltage machine and answers with up to seven action
// responses (events, enable writes, current writes, unlock) followed by one
// status response with last set; every response carries the state after the tick. A tick
// is accepted, then evaluated, then its responses go out one per cycle while the sink is
// ready; in charging with soft full timing active the current ramp also waits for the
// 16-step serial divider. The next request is taken once the status response is in the
// output register. Registers sit on the APB port at byte address 4*index; the user must
// write them only while no tick is in flight, and the block itself does not enforce it.
module usb_charge_state_controller (
   input  logic        clock,
   input  logic        reset,
   ucsc_req_if.sink    req_chan,
   ucsc_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   ucsc_pkg::cfg_type      cfg;
   ucsc_pkg::cmd_type      cmd;
   ucsc_pkg::status_type   stat;
   ucsc_pkg::req_item_type req_item;

   // request payload packing
   assign req_item.usb_present   = req_chan.usb_present;
   assign req_item.overvoltage   = req_chan.overvoltage;
   assign req_item.hardware_full = req_chan.hardware_full;
   assign req_item.charger_on    = req_chan.charger_on;
   assign req_item.battery_mv    = req_chan.battery_mv;
   assign req_item.system_busy   = req_chan.system_busy;

   ucsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ucsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ucsc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_item         (req_item),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_kind         (rsp_chan.kind),
      .rsp_value        (rsp_chan.value),
      .rsp_charge_state (rsp_chan.charge_state),
      .rsp_last         (rsp_chan.last)
   );

endmodule

### verif/usb_charge_state_controller_tb.sv
`timescale 1ns / 100ps

module usb_charge_state_controller_tb;
   import ucsc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SHOW_LIMIT  = 100;

   // one response as seen on the result channel
   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] value;
      logic [2:0] charge_state;
      logic       last;
   } action_t;

   // charger model and queue of responses still owed by the block
   class charge_scoreboard;
      cfg_type     cfg;
      logic [2:0]  state;
      logic        ovp_seen;
      logic        full_seen;
      logic [7:0]  insert_cnt;
      logic [7:0]  ovp_clear_cnt;
      logic [15:0] full_cnt;
      logic [15:0] reduce_cnt;
      action_t     tick_acts[$];
      action_t     pending_actions[$];
      int          errors;

      function new();
         cfg = cfg_type'{13'd4200, 13'd4050, 13'd4100, 4'd7, 4'd3, 16'd600, 16'd300, 3'd7};
         state = ST_IDLE;
         ovp_seen = 1'b0;
         full_seen = 1'b0;
         insert_cnt = 8'd0;
         ovp_clear_cnt = 8'd0;
         full_cnt = 16'd0;
         reduce_cnt = 16'd0;
         errors = 0;
      endfunction

      task flag_mismatch(input string msg);
         errors++;
         if (errors <= SHOW_LIMIT) $display("mismatch: %s", msg);
      endtask

      function void set_reg(input logic [2:0] idx, input logic [31:0] data);
         case (idx)
            REG_FULL_V:      cfg.full_voltage_mv = data[12:0];
            REG_RECHARGE_V:  cfg.recharge_voltage_mv = data[12:0];
            REG_REDUCE_V:    cfg.reduce_voltage_mv = data[12:0];
            REG_NORMAL_CUR:  cfg.normal_current_code = data[3:0];
            REG_REDUCED_CUR: cfg.reduced_current_code = data[3:0];
            REG_FULL_TICKS:  cfg.full_ticks = data[15:0];
            REG_RED_TICKS:   cfg.reduce_ticks = data[15:0];
            default:         cfg.feature_enables = data[2:0];
         endcase
      endfunction

      function void add_action(input logic [2:0] kind, input logic [3:0] value);
         if (tick_acts.size() < ACT_SLOTS) tick_acts.push_back('{kind, value, 3'd0, 1'b0});
      endfunction

      // one accepted request: step the charger and queue the responses it owes
      function void predict_tick_actions(input req_item_type t);
         action_t     a;
         int unsigned per;
         int unsigned stepnum;
         int unsigned top;
         logic        soft_full_on;
         soft_full_on = cfg.feature_enables[1];
         tick_acts.delete();

         // status latches
         if (t.usb_present && t.charger_on) full_seen = t.hardware_full;
         if (t.usb_present) ovp_seen = t.overvoltage;

         // removal from any active state
         if (!t.usb_present && state != ST_IDLE && state <= ST_OVP) begin
            if (state == ST_OVP) begin
               ovp_seen = 1'b0;
               ovp_clear_cnt = 8'd0;
            end
            state = ST_IDLE;
            add_action(K_EVENT, EV_REMOVE);
         end else begin
            case (state)
               ST_IDLE: begin
                  if (t.usb_present) begin
                     full_seen = 1'b0;
                     add_action(K_ENABLE, 4'd0);
                     if (!t.system_busy) begin
                        if (cfg.feature_enables[2]) add_action(K_EVENT, EV_LOCK);
                        add_action(K_UNLOCK, 4'd0);
                        if (ovp_seen) begin
                           add_action(K_EVENT, EV_OVP);
                           state = ST_OVP;
                        end
                        // insert debounce, not cleared by removal
                        insert_cnt = insert_cnt + 8'd1;
                        if (insert_cnt >= INSERT_DEBOUNCE) begin
                           insert_cnt = 8'd0;
                           if (cfg.feature_enables[0])
                              add_action(K_CURRENT, cfg.normal_current_code);
                           add_action(K_EVENT, EV_INPUT);
                           state = ST_CHARGING;
                           add_action(K_ENABLE, 4'd1);
                        end
                     end
                  end
               end
               ST_CHARGING: begin
                  if (ovp_seen) begin
                     add_action(K_EVENT, EV_OVP);
                     state = ST_OVP;
                  end
                  if (full_seen) begin
                     full_cnt = 16'd0;
                     add_action(K_EVENT, EV_FULL);
                     state = ST_FULL;
                  end
                  // current reduction timer
                  if (cfg.feature_enables[0] && t.battery_mv >= cfg.reduce_voltage_mv) begin
                     reduce_cnt = reduce_cnt + 16'd1;
                     if (reduce_cnt >= cfg.reduce_ticks) begin
                        reduce_cnt = 16'd0;
                        add_action(K_CURRENT, cfg.reduced_current_code);
                     end
                  end
                  // soft full timer with current ramp
                  if (soft_full_on && t.battery_mv >= cfg.full_voltage_mv) begin
                     full_cnt = full_cnt + 16'd1;
                     if (full_cnt >= cfg.full_ticks) begin
                        full_cnt = 16'd0;
                        add_action(K_EVENT, EV_FULL);
                        state = ST_FULL;
                        add_action(K_ENABLE, 4'd0);
                     end
                     per = cfg.full_ticks / RAMP_STEPS;
                     if (per == 0) per = 1;
                     if (full_cnt % per == 0) begin
                        stepnum = full_cnt / per;
                        top = (cfg.normal_current_code > CURRENT_500MA_CODE) ?
                              CURRENT_500MA_CODE : cfg.normal_current_code;
                        add_action(K_CURRENT, (stepnum >= top) ? 4'd0 : 4'(top - stepnum));
                     end
                  end
               end
               ST_FULL: begin
                  if (soft_full_on) begin
                     if (t.battery_mv < cfg.recharge_voltage_mv) begin
                        add_action(K_EVENT, EV_CHARGING);
                        state = ST_RECHARGE;
                        add_action(K_CURRENT, CURRENT_500MA_CODE);
                        add_action(K_ENABLE, 4'd1);
                     end else begin
                        add_action(K_ENABLE, 4'd0);
                     end
                  end
               end
               ST_RECHARGE: begin
                  if (soft_full_on && t.battery_mv >= cfg.full_voltage_mv) begin
                     full_cnt = full_cnt + 16'd1;
                     if (full_cnt >= cfg.full_ticks) begin
                        full_cnt = 16'd0;
                        add_action(K_EVENT, EV_FULL);
                        state = ST_FULL;
                        add_action(K_ENABLE, 4'd0);
                     end
                  end
                  if (full_seen) begin
                     full_cnt = 16'd0;
                     add_action(K_EVENT, EV_FULL);
                     state = ST_FULL;
                  end
               end
               ST_OVP: begin
                  if (!ovp_seen) begin
                     if (t.battery_mv >= cfg.full_voltage_mv) begin
                        add_action(K_EVENT, EV_FULL);
                        state = ST_FULL;
                        add_action(K_ENABLE, 4'd0);
                     end else begin
                        ovp_clear_cnt = ovp_clear_cnt + 8'd1;
                        if (ovp_clear_cnt >= OVP_DEBOUNCE) begin
                           ovp_clear_cnt = 8'd0;
                           add_action(K_EVENT, EV_CHARGING);
                           state = ST_CHARGING;
                           add_action(K_CURRENT, CURRENT_500MA_CODE);
                           add_action(K_ENABLE, 4'd1);
                        end
                     end
                  end
               end
               default: state = ST_IDLE;
            endcase
         end

         // closing status, then stamp the final state on every response
         tick_acts.push_back('{K_STATUS, 4'd0, 3'd0, 1'b1});
         foreach (tick_acts[i]) begin
            a = tick_acts[i];
            a.charge_state = state;
            pending_actions.push_back(a);
         end
      endfunction

      task check_action(input action_t got);
         action_t want;
         logic    bad;
         if (pending_actions.size() == 0) begin
            flag_mismatch($sformatf("response kind %0d value %0d state %0d last %0b, none owed",
                                    got.kind, got.value, got.charge_state, got.last));
            return;
         end
         want = pending_actions.pop_front();
         bad = 1'b0;
         if (got.kind !== want.kind) bad = 1'b1;
         if (got.value !== want.value) bad = 1'b1;
         if (got.charge_state !== want.charge_state) bad = 1'b1;
         if (got.last !== want.last) bad = 1'b1;
         if (bad)
            flag_mismatch($sformatf("got kind %0d value %0d state %0d last %0b, want %0d %0d %0d %0b",
                                    got.kind, got.value, got.charge_state, got.last,
                                    want.kind, want.value, want.charge_state, want.last));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int               send_idle_pct;
   int               stall_pct;
   int               cycles = 0;
   logic             plugged;
   charge_scoreboard sb;

   ucsc_req_if req_bus();
   ucsc_rsp_if rsp_bus();

   usb_charge_state_controller dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #2 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response sink: check accepted responses, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_action('{rsp_bus.kind, rsp_bus.value, rsp_bus.charge_state, rsp_bus.last});
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // offer one request, leaving valid high after it is taken
   task automatic send_tick(input req_item_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.usb_present <= t.usb_present;
      req_bus.overvoltage <= t.overvoltage;
      req_bus.hardware_full <= t.hardware_full;
      req_bus.charger_on <= t.charger_on;
      req_bus.battery_mv <= t.battery_mv;
      req_bus.system_busy <= t.system_busy;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      sb.predict_tick_actions(t);
   endtask

   task automatic apply_tick(input logic present, input logic ov, input logic hw_full,
                             input logic chg_on, input logic [12:0] mv, input logic busy);
      send_tick(req_item_type'{present, ov, hw_full, chg_on, mv, busy});
   endtask

   // stop sending and wait for every owed response
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_actions.size() != 0) @(posedge clock);
   endtask

   // register write, psel left high so back-to-back writes chain cleanly
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, data);
   endtask

   task automatic load_config(input cfg_type c);
      write_reg(REG_FULL_V, 32'(c.full_voltage_mv));
      write_reg(REG_RECHARGE_V, 32'(c.recharge_voltage_mv));
      write_reg(REG_REDUCE_V, 32'(c.reduce_voltage_mv));
      write_reg(REG_NORMAL_CUR, 32'(c.normal_current_code));
      write_reg(REG_REDUCED_CUR, 32'(c.reduced_current_code));
      write_reg(REG_FULL_TICKS, 32'(c.full_ticks));
      write_reg(REG_RED_TICKS, 32'(c.reduce_ticks));
      write_reg(REG_FEATURES, 32'(c.feature_enables));
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // plug sessions with voltages clustered on the thresholds, plus some noise
   function automatic req_item_type random_tick();
      req_item_type t;
      logic [31:0]  r;
      r = $urandom;
      t = r[$bits(req_item_type)-1:0];
      if ($urandom_range(99) < 8) return t;
      if (plugged) plugged = ($urandom_range(99) >= 4);
      else plugged = ($urandom_range(99) < 35);
      t.usb_present = plugged;
      t.overvoltage = ($urandom_range(99) < 6);
      t.hardware_full = ($urandom_range(99) < 6);
      t.charger_on = ($urandom_range(99) < 85);
      t.system_busy = ($urandom_range(99) < 10);
      case ($urandom_range(5))
         0, 1: t.battery_mv = sb.cfg.full_voltage_mv - 13'd1 + 13'($urandom_range(3));
         2: t.battery_mv = sb.cfg.reduce_voltage_mv - 13'd1 + 13'($urandom_range(2));
         3: t.battery_mv = sb.cfg.recharge_voltage_mv - 13'd1 + 13'($urandom_range(2));
         default: ;
      endcase
      return t;
   endfunction

   task automatic run_phase(input cfg_type c, input int idle_pct, input int stall, input int n);
      settle();
      load_config(c);
      send_idle_pct = idle_pct;
      stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         // hold off mid-phase until the block has drained
         if (i == n / 2) settle();
         send_tick(random_tick());
      end
   endtask

   initial begin
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.usb_present = 1'b0;
      req_bus.overvoltage = 1'b0;
      req_bus.hardware_full = 1'b0;
      req_bus.charger_on = 1'b0;
      req_bus.battery_mv = '0;
      req_bus.system_busy = 1'b0;
      rsp_bus.ready = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      plugged = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed walk on reset settings
      apply_tick(0, 0, 0, 0, 13'd0, 0);
      apply_tick(1, 1, 1, 1, 13'd8191, 1);
      apply_tick(1, 1, 0, 1, 13'd3000, 0);
      apply_tick(1, 1, 0, 0, 13'd3000, 0);
      apply_tick(1, 0, 0, 0, 13'd4200, 0);
      apply_tick(1, 0, 0, 0, 13'd4049, 0);
      apply_tick(1, 0, 1, 1, 13'd4100, 0);
      apply_tick(1, 0, 0, 0, 13'd4050, 0);
      apply_tick(0, 1, 1, 1, 13'd4200, 1);
      // insert debounce up to charging
      repeat (9) apply_tick(1, 0, 0, 1, 13'd3000, 0);
      apply_tick(1, 0, 0, 1, 13'd4150, 0);
      apply_tick(1, 0, 0, 1, 13'd4200, 0);
      apply_tick(1, 0, 1, 1, 13'd0, 0);
      apply_tick(1, 0, 0, 0, 13'd0, 0);
      apply_tick(1, 1, 0, 1, 13'd4300, 0);
      apply_tick(0, 0, 0, 0, 13'd0, 0);

      // random phases over several register settings
      run_phase(cfg_type'{13'd4200, 13'd4050, 13'd4100, 4'd7, 4'd3, 16'd8, 16'd3, 3'd7},
                0, 0, 60);
      run_phase(cfg_type'{13'd0, 13'd8191, 13'd8191, 4'd0, 4'd0, 16'd5, 16'd1, 3'd7},
                86, 0, 50);
      run_phase(cfg_type'{13'd4200, 13'd4050, 13'd4100, 4'd15, 4'd0, 16'd3, 16'd2, 3'd3},
                0, 86, 60);
      run_phase(cfg_type'{13'd8191, 13'd0, 13'd0, 4'd15, 4'd15, 16'd65535, 16'd65535, 3'd0},
                19, 19, 40);
      run_phase(cfg_type'{13'd4000, 13'd3900, 13'd3800, 4'd5, 4'd9, 16'd12, 16'd4, 3'd5},
                19, 19, 70);

      settle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
